// ===== design/smia_pkg.sv =====
// shared types and constants for the sign-magnitude alu
`default_nettype none
package smia_pkg;
	localparam int unsigned MagW = 64;
	localparam int unsigned OpW = 4;
	localparam int unsigned ErrW = 3;

	localparam logic [OpW-1:0] OP_ADD  = 4'd0;
	localparam logic [OpW-1:0] OP_SUB  = 4'd1;
	localparam logic [OpW-1:0] OP_MUL  = 4'd2;
	localparam logic [OpW-1:0] OP_MOD  = 4'd3;
	localparam logic [OpW-1:0] OP_POW  = 4'd4;
	localparam logic [OpW-1:0] OP_NEG  = 4'd5;
	localparam logic [OpW-1:0] OP_ABS  = 4'd6;
	localparam logic [OpW-1:0] OP_NZ   = 4'd7;
	localparam logic [OpW-1:0] OP_HASH = 4'd8;

	localparam logic [ErrW-1:0] ERR_OK   = 3'd0;
	localparam logic [ErrW-1:0] ERR_ADD  = 3'd1;
	localparam logic [ErrW-1:0] ERR_MUL  = 3'd2;
	localparam logic [ErrW-1:0] ERR_POW  = 3'd3;
	localparam logic [ErrW-1:0] ERR_NEXP = 3'd4;
	localparam logic [ErrW-1:0] ERR_DIV0 = 3'd5;

	localparam logic [63:0] HASH_MIX = 64'h0000_0000_9e37_79b9;

	typedef struct packed {
		logic [OpW-1:0] req_type;
		logic [MagW-1:0] a_mag;
		logic a_neg;
		logic [MagW-1:0] b_mag;
		logic b_neg;
	} req_t;

	typedef struct packed {
		logic [MagW-1:0] res_mag;
		logic res_neg;
		logic nonzero_flag;
		logic [ErrW-1:0] error_code;
	} rsp_t;

	// shared unit commands from the sequencer
	typedef struct packed {
		logic start_mul;
		logic start_div;
	} unit_cmd_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} unit_sts_t;
endpackage
`default_nettype wire

// ===== design/smia_if.sv =====
// valid/ready channel carrying one payload
`default_nettype none
interface smia_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/smia_unit.sv =====
// shared shift-add multiplier and restoring divider, one bit per cycle
`default_nettype none
module smia_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire smia_pkg::unit_cmd_t cmd,
	input wire logic [smia_pkg::MagW-1:0] x,
	input wire logic [smia_pkg::MagW-1:0] y,
	output smia_pkg::unit_sts_t sts,
	output logic [smia_pkg::MagW-1:0] result
);
	localparam int unsigned W = smia_pkg::MagW;
	localparam int unsigned CntW = $clog2(W);
	logic busy_q, is_div_q, ovf_q, done_q;
	logic [CntW-1:0] cnt_q;
	logic [W-1:0] acc_q, sh_q, opnd_q;
	logic [W:0] sum;
	logic [W:0] trial;
	logic [W-1:0] rem_sh;

	// multiply walks y from the msb: acc = 2*acc + x*bit
	assign sum = {acc_q, 1'b0} + {1'b0, (sh_q[W-1] ? opnd_q : {W{1'b0}})};
	assign rem_sh = {acc_q[W-2:0], sh_q[W-1]};
	assign trial = {acc_q[W-1], rem_sh} - {1'b0, opnd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			is_div_q <= 1'b0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start_mul || cmd.start_div) begin
				busy_q <= 1'b1;
				is_div_q <= cmd.start_div;
				ovf_q <= 1'b0;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (!is_div_q && (acc_q[W-1] || sum[W])) ovf_q <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_mul || cmd.start_div) begin
			acc_q <= '0;
			sh_q <= cmd.start_div ? x : y;
			opnd_q <= cmd.start_div ? y : x;
		end else if (busy_q) begin
			sh_q <= {sh_q[W-2:0], 1'b0};
			if (is_div_q) begin
				if (!trial[W]) acc_q <= trial[W-1:0];
				else acc_q <= rem_sh;
			end else begin
				acc_q <= sum[W-1:0];
			end
		end
	end

	assign sts = '{done: done_q, ovf: ovf_q};
	assign result = acc_q;
endmodule
`default_nettype wire

// ===== design/smia_seq.sv =====
// request sequencer: decodes the opcode and drives the shared unit
`default_nettype none
module smia_seq (
	input wire logic clk,
	input wire logic arst_n,
	smia_if.sink req,
	smia_if.source rsp
);
	localparam int unsigned W = smia_pkg::MagW;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_POW  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	smia_pkg::req_t r_q;
	smia_pkg::rsp_t out_q;
	smia_pkg::rsp_t unit_out;
	logic [6:0] pcnt_q;
	smia_pkg::unit_cmd_t cmd;
	smia_pkg::unit_sts_t sts;
	logic [W-1:0] ux, uy, ures;
	logic an, bn;
	logic [W:0] addsum;
	smia_pkg::rsp_t quick;
	logic [W-1:0] hmix;

	assign an = req.data.a_neg && (req.data.a_mag != '0);
	assign bn = req.data.b_neg && (req.data.b_mag != '0);
	assign hmix = req.data.a_mag ^ ({{(W-1){1'b0}}, !an} + smia_pkg::HASH_MIX
		+ (req.data.a_mag << 6) + (req.data.a_mag >> 2));

	// combinational results for requests that bypass the shared unit
	always_comb begin
		logic bsign;
		bsign = (req.data.req_type == smia_pkg::OP_SUB) ? !bn : bn;
		quick = '0;
		addsum = {1'b0, req.data.a_mag} + {1'b0, req.data.b_mag};
		unique case (req.data.req_type)
			smia_pkg::OP_ADD, smia_pkg::OP_SUB: begin
				if (an == bsign) begin
					if (addsum[W]) quick.error_code = smia_pkg::ERR_ADD;
					else begin
						quick.res_mag = addsum[W-1:0];
						quick.res_neg = an;
					end
				end else if (req.data.a_mag >= req.data.b_mag) begin
					quick.res_mag = req.data.a_mag - req.data.b_mag;
					quick.res_neg = an;
				end else begin
					quick.res_mag = req.data.b_mag - req.data.a_mag;
					quick.res_neg = bsign;
				end
			end
			smia_pkg::OP_MOD: if (req.data.b_mag == '0) quick.error_code = smia_pkg::ERR_DIV0;
			smia_pkg::OP_POW: begin
				if (bn) quick.error_code = smia_pkg::ERR_NEXP;
				else if (req.data.b_mag == '0) quick.res_mag = W'(1);
				else if (req.data.a_mag == W'(1)) begin
					quick.res_mag = W'(1);
					quick.res_neg = an && req.data.b_mag[0];
				end else if (req.data.a_mag != '0 && req.data.b_mag >= W'(64))
					quick.error_code = smia_pkg::ERR_POW;
			end
			smia_pkg::OP_NEG: begin
				quick.res_mag = req.data.a_mag;
				quick.res_neg = !an;
			end
			smia_pkg::OP_ABS: quick.res_mag = req.data.a_mag;
			smia_pkg::OP_NZ: quick.nonzero_flag = (req.data.a_mag != '0);
			smia_pkg::OP_HASH: quick.res_mag = hmix;
			default: quick = '0;
		endcase
		if (quick.res_mag == '0) quick.res_neg = 1'b0;
	end

	// result built from the shared unit output
	always_comb begin
		unit_out = '0;
		unique case (state_q)
			ST_MUL: begin
				if (sts.ovf) unit_out.error_code = smia_pkg::ERR_MUL;
				else begin
					unit_out.res_mag = ures;
					unit_out.res_neg = (r_q.a_neg != r_q.b_neg) && (ures != '0);
				end
			end
			ST_DIV: begin
				unit_out.res_mag = (r_q.a_neg != r_q.b_neg && ures != '0)
					? r_q.b_mag - ures : ures;
				unit_out.res_neg = r_q.b_neg && (ures != '0);
			end
			ST_POW: begin
				if (sts.ovf) unit_out.error_code = smia_pkg::ERR_POW;
				else begin
					unit_out.res_mag = ures;
					unit_out.res_neg = r_q.a_neg && r_q.b_mag[0];
				end
			end
			default: unit_out = '0;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE) && !(rsp.valid && !rsp.ready);

	always_comb begin
		cmd = '0;
		ux = r_q.a_mag;
		uy = r_q.b_mag;
		if (state_q == ST_IDLE && req.valid && req.ready) begin
			ux = req.data.a_mag;
			uy = req.data.b_mag;
			cmd.start_mul = (req.data.req_type == smia_pkg::OP_MUL);
			cmd.start_div = (req.data.req_type == smia_pkg::OP_MOD)
				&& (req.data.b_mag != '0);
			if (req.data.req_type == smia_pkg::OP_POW && !bn && req.data.a_mag > W'(1)
				&& req.data.b_mag != '0 && req.data.b_mag < W'(64)) begin
				cmd.start_mul = 1'b1;
				uy = W'(1);
			end
		end else if (state_q == ST_POW && sts.done && !sts.ovf && pcnt_q != 7'd1) begin
			cmd.start_mul = 1'b1;
			ux = r_q.a_mag;
			uy = ures;
		end
	end

	smia_unit u_unit (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .x(ux), .y(uy),
		.sts(sts), .result(ures)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp.valid <= 1'b0;
			pcnt_q <= '0;
		end else begin
			if ((state_q == ST_IDLE && req.valid && req.ready
				&& !cmd.start_div && !cmd.start_mul) || state_q == ST_OUT)
				rsp.valid <= 1'b1;
			else if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (req.valid && req.ready) begin
					if (cmd.start_div) state_q <= ST_DIV;
					else if (cmd.start_mul && req.data.req_type == smia_pkg::OP_POW) begin
						state_q <= ST_POW;
						pcnt_q <= req.data.b_mag[6:0];
					end else if (cmd.start_mul) state_q <= ST_MUL;
				end
				ST_MUL, ST_DIV: if (sts.done) state_q <= ST_OUT;
				ST_POW: if (sts.done) begin
					if (sts.ovf || pcnt_q == 7'd1) state_q <= ST_OUT;
					pcnt_q <= pcnt_q - 7'd1;
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid && req.ready) begin
			r_q <= '{req_type: req.data.req_type, a_mag: req.data.a_mag, a_neg: an,
				b_mag: req.data.b_mag, b_neg: bn};
			out_q <= quick;
		end else if ((state_q == ST_MUL || state_q == ST_DIV || state_q == ST_POW)
			&& sts.done) begin
			out_q <= unit_out;
		end
	end

	assign rsp.data = out_q;
endmodule
`default_nettype wire

// ===== design/sign_magnitude_integer_alu_top.sv =====
// top level of the sign-magnitude integer alu
// usage:
//   req channel carries req_type, a_mag, a_neg, b_mag, b_neg; rsp channel
//   returns res_mag, res_neg, nonzero_flag, error_code, one per request.
//   add, sub, neg, abs, nonzero test, hash and rejected requests answer
//   in the cycle after acceptance. mul and mod each make one pass through
//   the shared 64-step bit-serial multiply/divide unit. pow runs
//   the same unit once per exponent step for an exponent e below 64,
//   stopping early on overflow.
//   one request is in flight at a time; ready stays low while the unit
//   runs and while a finished result waits to be taken.
//   reset clears the sequencer and drops any pending result.
//   a stalled receiver holds the result register and blocks new requests.
`default_nettype none
module sign_magnitude_integer_alu_top (
	input wire logic clk,
	input wire logic arst_n,
	smia_if.sink req,
	smia_if.source rsp
);
	smia_seq u_seq (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	a_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.data.res_neg && rsp.data.res_mag == '0))
		else $error("negative zero result");
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.error_code != smia_pkg::ERR_OK)
		|-> (rsp.data.res_mag == '0 && !rsp.data.nonzero_flag))
		else $error("error result not cleared");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request taken while result stalled");
endmodule
`default_nettype wire
